### sv/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Types and constants shared by the variable partition allocator modules.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam logic [15:0] ID_MAX = 16'hFFFF;
    localparam logic [15:0] RESET_TOTAL = 16'd1024;
    localparam logic [15:0] RESET_SPLIT_FLOOR = 16'd10;

    localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;
    localparam logic [1:0] REG_FIT_POLICY = 2'd1;
    localparam logic [1:0] REG_SPLIT_FLOOR = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_FIT = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_NO_PROC = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_size;
        logic [15:0] process_id;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] granted_id;
        logic [15:0] block_start;
        logic [15:0] block_size;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;   // latch request, clear scan state
        logic used_step;  // examine used slot at index
        logic free_step;  // examine free slot at index
        logic commit;     // apply table update
        logic shift_step; // one shift move of free table
        logic rebuild;    // one-segment reset of free table
        logic [2:0] fail_status;
        logic fail;       // produce failure result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic used_done;
        logic free_done;
        logic shift_done;
        logic [2:0] early_status; // after used scan: OK or failure code
        logic [2:0] late_status;  // after free scan
    } sts_t;

endpackage

### sv/vpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: used-table scan, free-table scan, commit, shift, respond.
// ----------------------------------------------------------------------------
module vpa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          out_free,  // output register can take an item
    input  logic          cfg_rebuild,
    input  vpa_pkg::sts_t sts,
    output vpa_pkg::cmd_t cmd,
    output logic          done       // result ready to load into output reg
);
    import vpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_USED, S_FREE, S_COMMIT, S_SHIFT, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        done = 1'b0;
        s_ready = (state_reg == S_IDLE) && !cfg_rebuild;
        cmd.rebuild = cfg_rebuild;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_req = 1'b1;
                    state_next = S_USED;
                end
            end
            S_USED: begin
                cmd.used_step = 1'b1;
                if (sts.used_done) begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                if (sts.early_status != ST_OK) begin
                    cmd.fail = 1'b1;
                    cmd.fail_status = sts.early_status;
                    state_next = S_DONE;
                end else begin
                    cmd.free_step = 1'b1;
                    if (sts.free_done) begin
                        state_next = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                if (sts.late_status != ST_OK) begin
                    cmd.fail = 1'b1;
                    cmd.fail_status = sts.late_status;
                    state_next = S_DONE;
                end else begin
                    cmd.commit = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (sts.shift_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_req |=> state_reg == S_USED)
        else $error("load did not start used scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> state_reg == S_IDLE)
        else $error("done did not return to idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.commit && !cmd.shift_step)
        else $error("ready while updating tables");
endmodule

### sv/vpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_datapath
// Free and used tables, scan index, pick registers, split/merge arithmetic.
// ----------------------------------------------------------------------------
module vpa_datapath #(
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  vpa_pkg::req_t req,
    input  logic [15:0]   total_size,
    input  logic          fit_policy,
    input  logic [15:0]   split_floor,
    input  vpa_pkg::cmd_t cmd,
    output vpa_pkg::sts_t sts,
    output vpa_pkg::rsp_t rsp
);
    import vpa_pkg::*;

    localparam int FI_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int UI_W = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int FC_W = $clog2(FREE_SLOTS + 1);
    localparam int SC_W = (FREE_SLOTS > USED_SLOTS) ? FC_W : $clog2(USED_SLOTS + 1);
    localparam logic [ADDR_BITS-1:0] ZA = '0;

    // shift job kinds
    localparam logic [1:0] SHIFT_NONE = 2'd0;
    localparam logic [1:0] SHIFT_DROP = 2'd1;   // drop at pos, move entries down
    localparam logic [1:0] SHIFT_INSERT = 2'd2; // insert at pos, move entries up

    logic [ADDR_BITS-1:0] free_start_reg [FREE_SLOTS];
    logic [ADDR_BITS-1:0] free_len_reg   [FREE_SLOTS];
    logic [FC_W-1:0]      free_count_reg;
    logic [15:0]          used_id_mem    [USED_SLOTS];
    logic [ADDR_BITS-1:0] used_start_mem [USED_SLOTS];
    logic [ADDR_BITS-1:0] used_len_mem   [USED_SLOTS];
    logic [USED_SLOTS-1:0] used_valid_reg;
    logic [15:0]          last_id_reg;

    req_t                 req_reg;
    logic [SC_W-1:0]      idx_reg;
    logic                 slot_found_reg;
    logic [UI_W-1:0]      slot_reg;
    logic                 pick_found_reg;
    logic [FI_W-1:0]      pick_reg;
    logic [ADDR_BITS-1:0] pick_len_reg;
    logic                 scan_stop_reg;
    logic [FC_W-1:0]      pos_reg;
    logic [ADDR_BITS-1:0] blk_start_reg, blk_len_reg;
    logic [1:0]           shift_kind_reg;
    logic [FC_W-1:0]      shift_ptr_reg;
    rsp_t                 rsp_reg;

    // current used/free entries at scan index
    logic [UI_W-1:0] uidx;
    logic [FI_W-1:0] fidx;
    assign uidx = idx_reg[UI_W-1:0];
    assign fidx = idx_reg[FI_W-1:0];

    logic [ADDR_BITS-1:0] cur_fs, cur_fl;
    assign cur_fs = free_start_reg[fidx];
    assign cur_fl = free_len_reg[fidx];

    logic [ADDR_BITS-1:0] req_sz;
    assign req_sz = ADDR_BITS'(req_reg.request_size);

    logic free_scan_end;
    assign free_scan_end = ({{(SC_W-FC_W+1){1'b0}}, free_count_reg} <= {1'b0, idx_reg})
                           || scan_stop_reg;

    // merge decisions, from pos_reg (first free entry with start > block)
    logic [FI_W-1:0] prev_i, next_i;
    logic            has_prev, has_next, join_prev, join_next;
    logic [ADDR_BITS:0] prev_end, blk_end;
    assign has_prev = pos_reg != '0;
    assign has_next = pos_reg < free_count_reg;
    assign prev_i = FI_W'(pos_reg - FC_W'(1));
    assign next_i = FI_W'(pos_reg);
    assign prev_end = {1'b0, free_start_reg[prev_i]} + {1'b0, free_len_reg[prev_i]};
    assign blk_end = {1'b0, blk_start_reg} + {1'b0, blk_len_reg};
    assign join_prev = has_prev && (prev_end == {1'b0, blk_start_reg});
    assign join_next = has_next && (blk_end == {1'b0, free_start_reg[next_i]});

    logic [ADDR_BITS-1:0] pick_left;
    assign pick_left = pick_len_reg - req_sz;

    always_comb begin
        sts = '0;
        sts.used_done = (idx_reg == SC_W'(USED_SLOTS - 1)) || slot_found_reg
                        || (req_reg.mode == MODE_ALLOC && req_reg.request_size == '0);
        sts.free_done = free_scan_end;
        sts.shift_done = shift_kind_reg == SHIFT_NONE;
        if (req_reg.mode == MODE_ALLOC) begin
            if (req_reg.request_size == '0) sts.early_status = ST_ZERO_SIZE;
            else if (!slot_found_reg || last_id_reg >= ID_MAX) sts.early_status = ST_FULL;
            else sts.early_status = ST_OK;
            sts.late_status = pick_found_reg ? ST_OK : ST_NO_FIT;
        end else begin
            sts.early_status = slot_found_reg ? ST_OK : ST_NO_PROC;
            sts.late_status = (!join_prev && !join_next
                               && free_count_reg >= FC_W'(FREE_SLOTS)) ? ST_FULL : ST_OK;
        end
    end

    // found flag for this used slot in current mode
    logic used_hit;
    always_comb begin
        if (req_reg.mode == MODE_ALLOC) used_hit = !used_valid_reg[uidx];
        else used_hit = used_valid_reg[uidx] && used_id_mem[uidx] == req_reg.process_id;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FREE_SLOTS; i++) begin
                free_start_reg[i] <= ZA;
                free_len_reg[i] <= ZA;
            end
            free_len_reg[0] <= ADDR_BITS'(RESET_TOTAL);
            free_count_reg <= FC_W'(1);
            used_valid_reg <= '0;
            last_id_reg <= '0;
            shift_kind_reg <= SHIFT_NONE;
        end else begin
            if (cmd.rebuild) begin
                for (int i = 0; i < FREE_SLOTS; i++) begin
                    free_start_reg[i] <= ZA;
                    free_len_reg[i] <= ZA;
                end
                free_len_reg[0] <= ADDR_BITS'(total_size);
                free_count_reg <= FC_W'(1);
            end
            if (cmd.commit) begin
                if (req_reg.mode == MODE_ALLOC) begin
                    last_id_reg <= last_id_reg + 16'd1;
                    used_valid_reg[slot_reg] <= 1'b1;
                    if (pick_left >= ADDR_BITS'(split_floor)) begin
                        free_start_reg[pick_reg] <= free_start_reg[pick_reg] + req_sz;
                        free_len_reg[pick_reg] <= pick_left;
                    end else begin
                        shift_kind_reg <= SHIFT_DROP;
                        shift_ptr_reg <= FC_W'(pick_reg);
                    end
                end else begin
                    used_valid_reg[slot_reg] <= 1'b0;
                    if (join_prev && join_next) begin
                        free_len_reg[prev_i] <= free_len_reg[prev_i] + blk_len_reg
                                                + free_len_reg[next_i];
                        shift_kind_reg <= SHIFT_DROP;
                        shift_ptr_reg <= pos_reg;
                    end else if (join_prev) begin
                        free_len_reg[prev_i] <= free_len_reg[prev_i] + blk_len_reg;
                    end else if (join_next) begin
                        free_start_reg[next_i] <= blk_start_reg;
                        free_len_reg[next_i] <= free_len_reg[next_i] + blk_len_reg;
                    end else begin
                        shift_kind_reg <= SHIFT_INSERT;
                        shift_ptr_reg <= free_count_reg;
                    end
                end
            end
            if (cmd.shift_step) begin
                if (shift_kind_reg == SHIFT_DROP) begin
                    // move entry ptr+1 down into ptr, then shrink count at end
                    if (shift_ptr_reg + FC_W'(1) < free_count_reg) begin
                        free_start_reg[FI_W'(shift_ptr_reg)] <=
                            free_start_reg[FI_W'(shift_ptr_reg + FC_W'(1))];
                        free_len_reg[FI_W'(shift_ptr_reg)] <=
                            free_len_reg[FI_W'(shift_ptr_reg + FC_W'(1))];
                        shift_ptr_reg <= shift_ptr_reg + FC_W'(1);
                    end else begin
                        free_count_reg <= free_count_reg - FC_W'(1);
                        shift_kind_reg <= SHIFT_NONE;
                    end
                end else if (shift_kind_reg == SHIFT_INSERT) begin
                    if (shift_ptr_reg > pos_reg) begin
                        free_start_reg[FI_W'(shift_ptr_reg)] <=
                            free_start_reg[FI_W'(shift_ptr_reg - FC_W'(1))];
                        free_len_reg[FI_W'(shift_ptr_reg)] <=
                            free_len_reg[FI_W'(shift_ptr_reg - FC_W'(1))];
                        shift_ptr_reg <= shift_ptr_reg - FC_W'(1);
                    end else begin
                        free_start_reg[FI_W'(pos_reg)] <= blk_start_reg;
                        free_len_reg[FI_W'(pos_reg)] <= blk_len_reg;
                        free_count_reg <= free_count_reg + FC_W'(1);
                        shift_kind_reg <= SHIFT_NONE;
                    end
                end
            end
        end
    end

    // used table payload: written on allocate commit only
    always_ff @(posedge aclk) begin
        if (cmd.commit && req_reg.mode == MODE_ALLOC) begin
            used_id_mem[slot_reg] <= last_id_reg + 16'd1;
            used_start_mem[slot_reg] <= free_start_reg[pick_reg];
            used_len_mem[slot_reg] <= (pick_left >= ADDR_BITS'(split_floor)) ? req_sz
                                                                            : pick_len_reg;
        end
    end

    // scan and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= req;
            idx_reg <= '0;
            slot_found_reg <= 1'b0;
            pick_found_reg <= 1'b0;
            scan_stop_reg <= 1'b0;
            pos_reg <= '0;
        end
        if (cmd.used_step) begin
            if (!slot_found_reg && used_hit) begin
                slot_found_reg <= 1'b1;
                slot_reg <= uidx;
                blk_start_reg <= used_start_mem[uidx];
                blk_len_reg <= used_len_mem[uidx];
            end
            if (sts.used_done) idx_reg <= '0;
            else idx_reg <= idx_reg + SC_W'(1);
        end
        if (cmd.free_step && !free_scan_end) begin
            if (req_reg.mode == MODE_ALLOC) begin
                if (cur_fl >= req_sz) begin
                    if (!pick_found_reg || (fit_policy && cur_fl < pick_len_reg)) begin
                        pick_found_reg <= 1'b1;
                        pick_reg <= fidx;
                        pick_len_reg <= cur_fl;
                    end
                    if (!fit_policy) scan_stop_reg <= 1'b1;
                end
            end else begin
                if (cur_fs <= blk_start_reg) pos_reg <= FC_W'(idx_reg) + FC_W'(1);
                else scan_stop_reg <= 1'b1;
            end
            idx_reg <= idx_reg + SC_W'(1);
        end
        if (cmd.fail) begin
            rsp_reg <= '{status: cmd.fail_status, granted_id: '0,
                         block_start: '0, block_size: '0};
        end
        if (cmd.commit) begin
            rsp_reg.status <= ST_OK;
            if (req_reg.mode == MODE_ALLOC) begin
                rsp_reg.granted_id <= last_id_reg + 16'd1;
                rsp_reg.block_start <= 16'(free_start_reg[pick_reg]);
                rsp_reg.block_size <= 16'((pick_left >= ADDR_BITS'(split_floor)) ? req_sz
                                                                                : pick_len_reg);
            end else begin
                rsp_reg.granted_id <= req_reg.process_id;
                rsp_reg.block_start <= 16'(blk_start_reg);
                rsp_reg.block_size <= 16'(blk_len_reg);
            end
        end
    end

    assign rsp = rsp_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= FC_W'(FREE_SLOTS))
        else $error("free count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && req_reg.mode == MODE_ALLOC |=> last_id_reg == $past(last_id_reg) + 16'd1)
        else $error("id not advanced on allocate");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> slot_found_reg)
        else $error("commit without used slot");
endmodule

### sv/variable_partition_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First/best fit free-list allocator with merge on free.
// ----------------------------------------------------------------------------
// Result valid follows accept after the used scan, free scan and shift, each of which
//   steps one entry per cycle.
// Throughput: one item at a time; the next input is taken once the controller is
//   back in idle after the result loads, and waits on any result-side stall.
// Reset: synchronous active-low; free table one segment of 1024, no blocks.
// A total_size write rebuilds the free table.
module variable_partition_allocator #(
    parameter int FREE_SLOTS = 16,
    parameter int USED_SLOTS = 16,
    parameter int ADDR_BITS  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vpa_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vpa_pkg::rsp_t m_data,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);
    import vpa_pkg::*;

    logic [15:0] split_floor_reg;
    logic        fit_policy_reg;
    cmd_t        cmd;
    sts_t        sts;
    rsp_t        rsp;
    logic        done, out_free, cfg_rebuild;

    // size write goes straight to the rebuild; nothing else reads it later
    assign cfg_rebuild = cfg_we && cfg_index == REG_TOTAL_SIZE;
    assign out_free = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= 1'b0;
            split_floor_reg <= RESET_SPLIT_FLOOR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FIT_POLICY:  fit_policy_reg <= cfg_wdata[0];
                REG_SPLIT_FLOOR: split_floor_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vpa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .out_free, .cfg_rebuild,
        .sts, .cmd, .done
    );

    vpa_datapath #(
        .FREE_SLOTS(FREE_SLOTS), .USED_SLOTS(USED_SLOTS), .ADDR_BITS(ADDR_BITS)
    ) u_dp (
        .aclk, .aresetn, .req(s_data), .total_size(cfg_wdata),
        .fit_policy(fit_policy_reg), .split_floor(split_floor_reg),
        .cmd, .sts, .rsp
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else begin
            if (done) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) m_data <= rsp;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free)
        else $error("result overwrites pending item");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !done)
        else $error("ready while a result loads");
endmodule
